### hdl/assert_macros.svh
// assertion macros shared by the alpha-beta filter rtl
// expects clk and rst_n in the scope of each use; empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AABF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aabf assertion failed");
`define AABF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aabf assertion failed");
`else
`define AABF_ASSERT_IMPL(lbl, ante, cons)
`define AABF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/aabf_pkg.sv
// types and constants of the acceleration-aided alpha-beta filter
// no dependencies; used by the interfaces, the multiplier and the top level
`timescale 1ns / 1ps

package aabf_pkg;

  // field widths
  localparam int AXIS_W     = 2;
  localparam int POS_W      = 48;
  localparam int ROT_W      = 16;
  localparam int ACC_W      = 32;
  localparam int GAIN_W     = 17;
  localparam int STEP_W     = 21;
  localparam int INV_W      = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // datapath widths
  localparam int APROD_W   = 48;  // rotation times acceleration, Q.30
  localparam int ASUM_W    = 50;  // sum of three products
  localparam int ACC_ITERS = 8;   // radix-4 digits of the rotation term
  localparam int ACNT_W    = 3;
  localparam int MX_W      = 62;  // scaled-product operand and result
  localparam int MP_W      = 88;  // integer part times gain
  localparam int LO_W      = 20;  // fraction bits below the shift
  localparam int LP_W      = 47;  // fraction part times gain
  localparam int K_W       = 25;  // widest gain or time register
  localparam int MUL_ITERS = 13;  // radix-4 digits of the gain
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 63;  // state plus scaled product

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_ALPHA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_BETA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_ALPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_BETA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 3'd5;

  // configuration reset values
  localparam logic [GAIN_W-1:0] ALPHA_RST = 17'd32768;
  localparam logic [GAIN_W-1:0] BETA_RST  = 17'd8192;
  localparam logic [STEP_W-1:0] STEP_RST  = 21'd10486;
  localparam logic [INV_W-1:0]  INV_RST   = 25'd25600;

  // fixed-point constants
  localparam logic signed [MX_W-1:0]  GRAVITY_Q16 = 62'sd642689;
  localparam logic signed [MP_W-1:0]  PROD_LIM    = 88'sh1000_0000_0000_0000;
  localparam logic signed [MP_W-1:0]  PROD_LIM_N  = -PROD_LIM;
  localparam logic signed [POS_W-1:0] POS_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN     = 48'sh8000_0000_0000;
  localparam logic signed [SUM_W-1:0] SAT_HI      = 63'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SAT_LO      = -SAT_HI - 63'sd1;

  // right shift applied after a scaled product
  typedef enum logic [1:0] {
    SH_8  = 2'd0,
    SH_16 = 2'd1,
    SH_20 = 2'd2
  } shift_sel_t;

  // product currently in the multiplier
  typedef enum logic [2:0] {
    OP_VEL   = 3'd0,
    OP_POS   = 3'd1,
    OP_ALPHA = 3'd2,
    OP_BETA  = 3'd3,
    OP_INV   = 3'd4
  } filt_op_t;

  typedef struct packed {
    logic       start;
    shift_sel_t sh;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  typedef struct packed {
    logic                    clip;
    logic signed [POS_W-1:0] val;
  } sat_t;

endpackage

### hdl/aabf_in_if.sv
// input channel of the alpha-beta filter: one axis per transaction
// depends on aabf_pkg
`timescale 1ns / 1ps

interface aabf_in_if;
  import aabf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       axis;
  logic signed [POS_W-1:0] gps_position;
  logic signed [ROT_W-1:0] rot_col_x;
  logic signed [ROT_W-1:0] rot_col_y;
  logic signed [ROT_W-1:0] rot_col_z;
  logic signed [ACC_W-1:0] accel_body_x;
  logic signed [ACC_W-1:0] accel_body_y;
  logic signed [ACC_W-1:0] accel_body_z;

  modport source (
    output valid, axis, gps_position, rot_col_x, rot_col_y, rot_col_z,
    output accel_body_x, accel_body_y, accel_body_z,
    input  ready
  );

  modport sink (
    input  valid, axis, gps_position, rot_col_x, rot_col_y, rot_col_z,
    input  accel_body_x, accel_body_y, accel_body_z,
    output ready
  );

endinterface

### hdl/aabf_out_if.sv
// result channel of the alpha-beta filter: one fused position per transaction
// depends on aabf_pkg
`timescale 1ns / 1ps

interface aabf_out_if;
  import aabf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       axis_out;
  logic signed [POS_W-1:0] fused_position;
  logic                    saturated;

  modport source (
    output valid, axis_out, fused_position, saturated,
    input  ready
  );

  modport sink (
    input  valid, axis_out, fused_position, saturated,
    output ready
  );

endinterface

### hdl/accel_aided_alpha_beta_filter.sv
// Filter update: an input transaction runs the rotation lanes, then five scaled products in a row
// on the shared radix-4 multiplier; the first item of an axis and axis 3 skip both and go straight
// to the result stage. One item is in flight at a time; the next is taken once the result register
// loads and the sequencer returns to idle.
// Synchronous active-low reset restores the register defaults and marks every axis unstarted.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module accel_aided_alpha_beta_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  aabf_in_if.sink                              in_chan,
  aabf_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [aabf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aabf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import aabf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ACC    = 9'b000000010,
    S_ASUM   = 9'b000000100,
    S_AFIN   = 9'b000001000,
    S_MSTART = 9'b000010000,
    S_MWAIT  = 9'b000100000,
    S_RES    = 9'b001000000,
    S_WB     = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  localparam logic [ACNT_W-1:0] ACNT_LAST = ACNT_W'(ACC_ITERS - 1);

  state_t                  st_r, st_nxt;
  filt_op_t                op_r;
  logic [ACNT_W-1:0]       acnt_r;
  logic [AXIS_W-1:0]       ax_r;
  logic signed [POS_W-1:0] gps_r;
  logic signed [ASUM_W-1:0] asum_r;
  logic signed [MX_W-1:0]  xop_r;
  logic signed [POS_W-1:0] vel_r, pred_r, pos_r;
  logic                    clip_r;

  // configuration registers
  logic [GAIN_W-1:0] halpha_r, hbeta_r, valpha_r, vbeta_r;
  logic [STEP_W-1:0] step_r;
  logic [INV_W-1:0]  inv_r;

  // per-axis state
  logic signed [POS_W-1:0] pest_r [3];
  logic signed [POS_W-1:0] vest_r [3];
  logic [2:0]              started_r;

  // rotation lanes
  logic signed [ROT_W-1:0]   rot_in  [3];
  logic signed [ACC_W-1:0]   acc_in  [3];
  logic [ROT_W-1:0]          rsh_r   [3];
  logic signed [APROD_W-1:0] am_r    [3];
  logic signed [APROD_W-1:0] am3_r   [3];
  logic signed [APROD_W-1:0] lsum_r  [3];
  logic signed [APROD_W-1:0] adig    [3];
  logic signed [APROD_W-1:0] am_in   [3];

  // result register
  logic                    out_valid_r;
  logic [AXIS_W-1:0]       oax_r;
  logic signed [POS_W-1:0] opos_r;
  logic                    osat_r;

  // multiplier
  mul_ctl_t               mul_ctl;
  mul_sts_t               mul_sts;
  logic [K_W-1:0]         mul_k;
  logic signed [MX_W-1:0] mul_res;

  logic                    in_fire, short_path, out_free;
  logic signed [POS_W-1:0] base;
  logic signed [SUM_W-1:0] upd_sum;
  sat_t                    upd;
  logic signed [MX_W-1:0]  acc_q16;
  logic signed [MX_W-1:0]  resid;

  function automatic sat_t sat_pos(input logic signed [SUM_W-1:0] v);
    sat_t s;
    if (v > SAT_HI) begin
      s.clip = 1'b1;
      s.val  = POS_MAX;
    end else if (v < SAT_LO) begin
      s.clip = 1'b1;
      s.val  = POS_MIN;
    end else begin
      s.clip = 1'b0;
      s.val  = v[POS_W-1:0];
    end
    return s;
  endfunction

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  // axis 3 or a first item needs no filtering
  assign short_path = (in_chan.axis == AXIS_NONE) || !started_r[in_chan.axis];

  assign in_chan.ready           = (st_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.axis_out       = oax_r;
  assign out_chan.fused_position = opos_r;
  assign out_chan.saturated      = osat_r;

  // lane inputs, rotation element paired with body acceleration
  always_comb begin
    rot_in[0] = in_chan.rot_col_x;
    rot_in[1] = in_chan.rot_col_y;
    rot_in[2] = in_chan.rot_col_z;
    acc_in[0] = in_chan.accel_body_x;
    acc_in[1] = in_chan.accel_body_y;
    acc_in[2] = in_chan.accel_body_z;
    for (int i = 0; i < 3; i++) begin
      am_in[i] = {{(APROD_W-ACC_W){acc_in[i][ACC_W-1]}}, acc_in[i]};
    end
  end

  // lane digit select; the top digit carries the sign of the rotation term
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (acnt_r == ACNT_LAST) begin
        case (rsh_r[i][1:0])
          2'd0:    adig[i] = '0;
          2'd1:    adig[i] = am_r[i];
          2'd2:    adig[i] = -(am_r[i] <<< 1);
          default: adig[i] = -am_r[i];
        endcase
      end else begin
        case (rsh_r[i][1:0])
          2'd0:    adig[i] = '0;
          2'd1:    adig[i] = am_r[i];
          2'd2:    adig[i] = am_r[i] <<< 1;
          default: adig[i] = am3_r[i];
        endcase
      end
    end
  end

  // world acceleration in Q.16 and GPS residual
  always_comb begin
    acc_q16 = $signed({{(MX_W-ASUM_W){asum_r[ASUM_W-1]}}, asum_r}) >>> 14;
    if (ax_r == AXIS_Z) begin
      acc_q16 = acc_q16 - GRAVITY_Q16;
    end
    resid = $signed({{(MX_W-POS_W){gps_r[POS_W-1]}}, gps_r})
          - $signed({{(MX_W-POS_W){pred_r[POS_W-1]}}, pred_r});
  end

  // multiplier operands by step
  always_comb begin
    mul_ctl.start = (st_r == S_MSTART);
    case (op_r)
      OP_VEL, OP_POS: begin
        mul_k      = K_W'(step_r);
        mul_ctl.sh = SH_20;
      end
      OP_ALPHA: begin
        mul_k      = (ax_r == AXIS_Z) ? K_W'(valpha_r) : K_W'(halpha_r);
        mul_ctl.sh = SH_16;
      end
      OP_BETA: begin
        mul_k      = (ax_r == AXIS_Z) ? K_W'(vbeta_r) : K_W'(hbeta_r);
        mul_ctl.sh = SH_16;
      end
      OP_INV: begin
        mul_k      = inv_r;
        mul_ctl.sh = SH_8;
      end
      default: begin
        mul_k      = '0;
        mul_ctl.sh = SH_8;
      end
    endcase
  end

  aabf_mulsh u_mulsh (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .x     (xop_r),
    .k     (mul_k),
    .sts   (mul_sts),
    .res   (mul_res)
  );

  // one saturating adder shared by all state updates
  always_comb begin
    case (op_r)
      OP_VEL:   base = vest_r[ax_r];
      OP_POS:   base = pest_r[ax_r];
      OP_ALPHA: base = pred_r;
      OP_INV:   base = vel_r;
      default:  base = '0;
    endcase
    upd_sum = {{(SUM_W-POS_W){base[POS_W-1]}}, base}
            + {{(SUM_W-MX_W){mul_res[MX_W-1]}}, mul_res};
    upd = sat_pos(upd_sum);
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = short_path ? S_OUT : S_ACC;
        end
      end
      S_ACC: begin
        if (acnt_r == ACNT_LAST) begin
          st_nxt = S_ASUM;
        end
      end
      S_ASUM:   st_nxt = S_AFIN;
      S_AFIN:   st_nxt = S_MSTART;
      S_MSTART: st_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_sts.done) begin
          case (op_r)
            OP_POS:  st_nxt = S_RES;
            OP_INV:  st_nxt = S_WB;
            default: st_nxt = S_MSTART;
          endcase
        end
      end
      S_RES:    st_nxt = S_MSTART;
      S_WB:     st_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default:  st_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and axis flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= '0;
      halpha_r    <= ALPHA_RST;
      hbeta_r     <= BETA_RST;
      valpha_r    <= ALPHA_RST;
      vbeta_r     <= BETA_RST;
      step_r      <= STEP_RST;
      inv_r       <= INV_RST;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && in_chan.axis != AXIS_NONE) begin
        started_r[in_chan.axis] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HORIZ_ALPHA:  halpha_r <= cfg_data[GAIN_W-1:0];
          CFG_HORIZ_BETA:   hbeta_r  <= cfg_data[GAIN_W-1:0];
          CFG_VERT_ALPHA:   valpha_r <= cfg_data[GAIN_W-1:0];
          CFG_VERT_BETA:    vbeta_r  <= cfg_data[GAIN_W-1:0];
          CFG_STEP_TIME:    step_r   <= cfg_data[STEP_W-1:0];
          CFG_INVERSE_STEP: inv_r    <= cfg_data[INV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r   <= in_chan.axis;
      gps_r  <= in_chan.gps_position;
      acnt_r <= '0;
      clip_r <= 1'b0;
      pos_r  <= (in_chan.axis == AXIS_NONE) ? '0 : in_chan.gps_position;
      for (int i = 0; i < 3; i++) begin
        rsh_r[i]  <= rot_in[i];
        am_r[i]   <= am_in[i];
        am3_r[i]  <= am_in[i] + (am_in[i] <<< 1);
        lsum_r[i] <= '0;
      end
      // first item of an axis loads the GPS fix
      if (short_path && in_chan.axis != AXIS_NONE) begin
        pest_r[in_chan.axis] <= in_chan.gps_position;
        vest_r[in_chan.axis] <= '0;
      end
    end

    if (st_r == S_ACC) begin
      acnt_r <= acnt_r + 1'b1;
      for (int i = 0; i < 3; i++) begin
        lsum_r[i] <= lsum_r[i] + adig[i];
        am_r[i]   <= am_r[i] <<< 2;
        am3_r[i]  <= am3_r[i] <<< 2;
        rsh_r[i]  <= rsh_r[i] >> 2;
      end
    end

    if (st_r == S_ASUM) begin
      asum_r <= {{(ASUM_W-APROD_W){lsum_r[0][APROD_W-1]}}, lsum_r[0]}
              + {{(ASUM_W-APROD_W){lsum_r[1][APROD_W-1]}}, lsum_r[1]}
              + {{(ASUM_W-APROD_W){lsum_r[2][APROD_W-1]}}, lsum_r[2]};
    end

    if (st_r == S_AFIN) begin
      xop_r <= acc_q16;
      op_r  <= OP_VEL;
    end

    if (st_r == S_RES) begin
      xop_r <= resid;
      op_r  <= OP_ALPHA;
    end

    // fold each finished product into the state or the next operand
    if (st_r == S_MWAIT && mul_sts.done) begin
      case (op_r)
        OP_VEL: begin
          vel_r  <= upd.val;
          clip_r <= clip_r | upd.clip;
          xop_r  <= {{(MX_W-POS_W){upd.val[POS_W-1]}}, upd.val};
          op_r   <= OP_POS;
        end
        OP_POS: begin
          pred_r <= upd.val;
          clip_r <= clip_r | upd.clip;
        end
        OP_ALPHA: begin
          pos_r  <= upd.val;
          clip_r <= clip_r | upd.clip;
          op_r   <= OP_BETA;
        end
        OP_BETA: begin
          xop_r <= mul_res;
          op_r  <= OP_INV;
        end
        OP_INV: begin
          vel_r  <= upd.val;
          clip_r <= clip_r | upd.clip;
        end
        default: ;
      endcase
    end

    if (st_r == S_WB) begin
      pest_r[ax_r] <= pos_r;
      vest_r[ax_r] <= vel_r;
    end

    if (st_r == S_OUT && out_free) begin
      oax_r  <= ax_r;
      opos_r <= pos_r;
      osat_r <= clip_r;
    end
  end

  `AABF_ASSERT_IMPL(a_mul_idle_on_start, st_r == S_MSTART, !mul_sts.busy)
  `AABF_ASSERT_NEXT(a_unused_axis_short, in_fire && in_chan.axis == AXIS_NONE, st_r == S_OUT)
  `AABF_ASSERT_IMPL(a_lanes_real_axis, st_r == S_ACC, ax_r != AXIS_NONE)
  `AABF_ASSERT_IMPL(a_sat_real_axis, out_chan.valid && out_chan.saturated, out_chan.axis_out != AXIS_NONE)

endmodule

### hdl/aabf_mulsh.sv
// radix-4 shift-add unit: floor(x * k / 2^s), held at +-2^60
// depends on aabf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aabf_mulsh (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aabf_pkg::mul_ctl_t               ctl,
  input  logic signed [aabf_pkg::MX_W-1:0] x,
  input  logic [aabf_pkg::K_W-1:0]         k,
  output aabf_pkg::mul_sts_t               sts,
  output logic signed [aabf_pkg::MX_W-1:0] res
);
  import aabf_pkg::*;

  logic signed [MX_W-1:0] hi;
  logic [LO_W-1:0]        lo;
  logic signed [MP_W-1:0] hi_ext;
  logic [LP_W-1:0]        lo_ext;
  logic signed [MP_W-1:0] mc_r;
  logic signed [MP_W-1:0] mc3_r;
  logic signed [MP_W-1:0] pacc_r;
  logic signed [MP_W-1:0] pdig;
  logic [LP_W-1:0]        lmc_r;
  logic [LP_W-1:0]        lmc3_r;
  logic [LP_W-1:0]        lacc_r;
  logic [LP_W-1:0]        ldig;
  logic [K_W-1:0]         k_r;
  logic [K_W-1:0]         tail;
  shift_sel_t             sh_r;
  logic signed [MX_W-1:0] res_fin;
  logic signed [MX_W-1:0] res_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   fin_r, fin_nxt;
  logic                   done_r, done_nxt;

  // split the operand into integer part and fraction below the shift
  always_comb begin
    case (ctl.sh)
      SH_20: begin
        hi = x >>> 20;
        lo = x[19:0];
      end
      SH_16: begin
        hi = x >>> 16;
        lo = LO_W'(x[15:0]);
      end
      SH_8: begin
        hi = x >>> 8;
        lo = LO_W'(x[7:0]);
      end
      default: begin
        hi = x;
        lo = '0;
      end
    endcase
    hi_ext = {{(MP_W-MX_W){hi[MX_W-1]}}, hi};
    lo_ext = LP_W'(lo);
  end

  // partial products for the current gain digit
  always_comb begin
    case (k_r[1:0])
      2'd0: begin
        pdig = '0;
        ldig = '0;
      end
      2'd1: begin
        pdig = mc_r;
        ldig = lmc_r;
      end
      2'd2: begin
        pdig = mc_r <<< 1;
        ldig = lmc_r << 1;
      end
      default: begin
        pdig = mc3_r;
        ldig = lmc3_r;
      end
    endcase
  end

  // fraction contribution after the shift, below the gain value
  always_comb begin
    case (sh_r)
      SH_20:   tail = K_W'(lacc_r >> 20);
      SH_16:   tail = K_W'(lacc_r >> 16);
      SH_8:    tail = K_W'(lacc_r >> 8);
      default: tail = '0;
    endcase
  end

  // hold at the product limit, decided on the integer part alone
  always_comb begin
    if (pacc_r > PROD_LIM) begin
      res_fin = PROD_LIM[MX_W-1:0];
    end else if (pacc_r < PROD_LIM_N) begin
      res_fin = PROD_LIM_N[MX_W-1:0];
    end else begin
      res_fin = pacc_r[MX_W-1:0] + MX_W'(tail);
    end
  end

  // digit counter and handshake
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = 1'b0;
    done_nxt = fin_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_ITERS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // shift-add datapath, two gain bits per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mc_r   <= hi_ext;
      mc3_r  <= hi_ext + (hi_ext <<< 1);
      lmc_r  <= lo_ext;
      lmc3_r <= lo_ext + (lo_ext << 1);
      pacc_r <= '0;
      lacc_r <= '0;
      k_r    <= k;
      sh_r   <= ctl.sh;
    end else if (busy_r) begin
      pacc_r <= pacc_r + pdig;
      lacc_r <= lacc_r + ldig;
      mc_r   <= mc_r <<< 2;
      mc3_r  <= mc3_r <<< 2;
      lmc_r  <= lmc_r << 2;
      lmc3_r <= lmc3_r << 2;
      k_r    <= k_r >> 2;
    end
    if (fin_r) begin
      res_r <= res_fin;
    end
  end

  assign sts.busy = busy_r | fin_r;
  assign sts.done = done_r;
  assign res      = res_r;

  `AABF_ASSERT_IMPL(a_start_when_idle, ctl.start, !busy_r && !fin_r)
  `AABF_ASSERT_NEXT(a_done_single, done_r, !done_r)
  `AABF_ASSERT_IMPL(a_cnt_bound, busy_r, cnt_r < CNT_W'(MUL_ITERS))

endmodule
